@@ hdl/lrsr_pkg.sv @@
// Shared types and constants for the LED ring shape rasterizer.
package lrsr_pkg;

    localparam int IDX_W  = 6;
    localparam int LVL_W  = 8;
    localparam int KIND_W = 2;
    localparam int EXT_W  = 6;
    // Divider and counter width: holds every value up to the largest ring size of 64.
    localparam int DW     = 7;
    localparam int SC_W   = 3;
    localparam int Q_AW   = 1;
    localparam int Q_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_POINT   = 2'd0,
        KIND_LINE    = 2'd1,
        KIND_SNAKE   = 2'd2,
        KIND_POLYGON = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STEP_UP,
        STEP_DOWN,
        STEP_POLY
    } step_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIVN,
        F_PUSH
    } front_state_t;

    // One classified command, ready for the write sequencer.
    typedef struct packed {
        step_t             step;
        logic [IDX_W-1:0]  start;
        logic [DW-1:0]     count;
        logic [LVL_W-1:0]  level;
        logic              light;
        logic              snake;
        logic [DW-1:0]     quo;
        logic [DW-1:0]     rem;
        logic [DW-1:0]     sides;
    } cmd_t;

endpackage

@@ hdl/led_ring_shape_rasterizer.sv @@
// Top level of the LED ring shape rasterizer: front end, command queue, write sequencer.
//
// Each transaction on the s_ channel is one shape command (point, line, snake or
// polygon) for a ring of RING_SIZE LEDs. The m_ channel answers with a run of LED
// writes, one transaction per LED, and m_last marks the final write of each run.
// The cfg_ channel writes the snake brightness floor; cfg_ready is always high, and
// writes are expected only while no command is in flight.
//
// The front end reduces the position modulo the ring size with a short chain of
// compare-and-subtract steps in the accepting cycle. For polygons it then divides
// the ring size by the side count, one quotient bit per cycle, before it offers the
// command. A two-entry queue separates it from the write sequencer, which emits one
// write per cycle while the receiver accepts them, and takes the next command from
// the queue only after the last write of the current one.
//
// Reset (aresetn low at a clock edge) empties the queue, drops any run in progress
// and sets the floor to 1. When the receiver holds m_ready low, the current write
// stays on the m_ ports unchanged, the sequencer waits, the queue fills, and then
// the front end stops accepting commands.
module led_ring_shape_rasterizer #(
    parameter int RING_SIZE = 60
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lrsr_pkg::KIND_W-1:0] s_kind,
    input  logic [lrsr_pkg::IDX_W-1:0]  s_position,
    input  logic [lrsr_pkg::EXT_W-1:0]  s_extent,
    input  logic [lrsr_pkg::LVL_W-1:0]  s_level,
    input  logic                        s_clockwise,
    input  logic                        s_visible,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lrsr_pkg::IDX_W-1:0]  m_led_index,
    output logic [lrsr_pkg::LVL_W-1:0]  m_led_level,
    output logic                        m_light,
    output logic                        m_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrsr_pkg::LVL_W-1:0]  cfg_data
);

    logic [lrsr_pkg::LVL_W-1:0] min_level_reg, min_level_next;
    logic                       push_valid, push_ready;
    logic                       pop_valid, pop_ready;
    lrsr_pkg::cmd_t             push_cmd, pop_cmd;

    // The floor register accepts a write on every cycle.
    assign cfg_ready      = 1'b1;
    assign min_level_next = (cfg_valid && cfg_ready) ? cfg_data : min_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_level_reg <= lrsr_pkg::LVL_W'(1);
        end else begin
            min_level_reg <= min_level_next;
        end
    end

    lrsr_front #(
        .RING_SIZE (RING_SIZE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_position  (s_position),
        .s_extent    (s_extent),
        .s_level     (s_level),
        .s_clockwise (s_clockwise),
        .s_visible   (s_visible),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    lrsr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    lrsr_back #(
        .RING_SIZE (RING_SIZE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .min_level   (min_level_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_led_index (m_led_index),
        .m_led_level (m_led_level),
        .m_light     (m_light),
        .m_last      (m_last)
    );

endmodule

@@ hdl/lrsr_front.sv @@
// Front end: accepts shape commands, reduces the position and classifies the walk.
module lrsr_front #(
    parameter int RING_SIZE = 60
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lrsr_pkg::KIND_W-1:0] s_kind,
    input  logic [lrsr_pkg::IDX_W-1:0]  s_position,
    input  logic [lrsr_pkg::EXT_W-1:0]  s_extent,
    input  logic [lrsr_pkg::LVL_W-1:0]  s_level,
    input  logic                        s_clockwise,
    input  logic                        s_visible,
    output logic                        push_valid,
    input  logic                        push_ready,
    output lrsr_pkg::cmd_t              push_cmd
);

    localparam logic [lrsr_pkg::DW-1:0] R_W = lrsr_pkg::DW'(RING_SIZE);

    lrsr_pkg::front_state_t state_reg, state_next;
    lrsr_pkg::kind_t               kind_reg, kind_next;
    logic [lrsr_pkg::DW-1:0]       n_reg, n_next;
    logic [lrsr_pkg::LVL_W-1:0]    level_reg, level_next;
    logic                          cw_reg, cw_next;
    logic                          vis_reg, vis_next;
    logic [lrsr_pkg::IDX_W-1:0]    p_reg, p_next;
    logic [lrsr_pkg::DW-1:0]       dvd_reg, dvd_next;
    logic [lrsr_pkg::DW-1:0]       dvs_reg, dvs_next;
    logic [lrsr_pkg::DW-1:0]       rem_reg, rem_next;
    logic [lrsr_pkg::DW-1:0]       quo_reg, quo_next;
    logic [lrsr_pkg::SC_W-1:0]     cnt_reg, cnt_next;
    logic [lrsr_pkg::DW-1:0]       pq_reg, pq_next;
    logic [lrsr_pkg::DW-1:0]       pr_reg, pr_next;

    logic [lrsr_pkg::DW-1:0]       rem_sh, rem_step, quo_step;
    logic                          ge;
    logic                          last_step;
    logic [lrsr_pkg::DW-1:0]       ext_w, n_clamp;
    logic [lrsr_pkg::DW-1:0]       p_w, far_cw, far_ccw;
    logic                          cw_eff;
    lrsr_pkg::cmd_t                cmd;

    // Position modulo the ring size: subtract each power-of-two multiple of the ring
    // size that fits below the largest encodable position, when the value reaches it.
    function automatic logic [lrsr_pkg::IDX_W-1:0] ring_mod(
        input logic [lrsr_pkg::IDX_W-1:0] v
    );
        logic [lrsr_pkg::DW-1:0] r;
        r = {1'b0, v};
        for (int k = lrsr_pkg::IDX_W - 1; k >= 0; k--) begin
            if ((RING_SIZE << k) < (1 << lrsr_pkg::IDX_W)) begin
                if (r >= lrsr_pkg::DW'(RING_SIZE << k)) begin
                    r = r - lrsr_pkg::DW'(RING_SIZE << k);
                end
            end
        end
        return r[lrsr_pkg::IDX_W-1:0];
    endfunction

    // One restoring division step per cycle.
    always_comb begin
        rem_sh   = {rem_reg[lrsr_pkg::DW-2:0], dvd_reg[lrsr_pkg::DW-1]};
        ge       = (rem_sh >= dvs_reg);
        rem_step = ge ? (rem_sh - dvs_reg) : rem_sh;
        quo_step = {quo_reg[lrsr_pkg::DW-2:0], ge};
        last_step = (cnt_reg == lrsr_pkg::SC_W'(lrsr_pkg::DW - 1));
    end

    always_comb begin
        ext_w = {1'b0, s_extent};
        if (s_extent == '0) begin
            n_clamp = lrsr_pkg::DW'(1);
        end else if (ext_w > R_W) begin
            n_clamp = R_W;
        end else begin
            n_clamp = ext_w;
        end
    end

    // Far ends of a line or snake: both sums stay below twice the ring size.
    always_comb begin
        p_w     = {1'b0, p_reg};
        far_cw  = p_w + n_reg - lrsr_pkg::DW'(1);
        if (far_cw >= R_W) begin
            far_cw = far_cw - R_W;
        end
        far_ccw = p_w + (R_W - n_reg) + lrsr_pkg::DW'(1);
        if (far_ccw >= R_W) begin
            far_ccw = far_ccw - R_W;
        end
        cw_eff = (kind_reg == lrsr_pkg::KIND_LINE) ? 1'b1 : cw_reg;
    end

    always_comb begin
        cmd.step  = lrsr_pkg::STEP_UP;
        cmd.start = p_reg;
        cmd.count = n_reg;
        cmd.level = vis_reg ? level_reg : '0;
        cmd.light = vis_reg;
        cmd.snake = 1'b0;
        cmd.quo   = pq_reg;
        cmd.rem   = pr_reg;
        cmd.sides = n_reg;
        unique case (kind_reg)
            lrsr_pkg::KIND_POINT: begin
                cmd.count = lrsr_pkg::DW'(1);
            end
            lrsr_pkg::KIND_POLYGON: begin
                cmd.step = lrsr_pkg::STEP_POLY;
            end
            default: begin
                cmd.snake = (kind_reg == lrsr_pkg::KIND_SNAKE);
                if (vis_reg) begin
                    if (cw_eff) begin
                        cmd.start = far_cw[lrsr_pkg::IDX_W-1:0];
                        cmd.step  = lrsr_pkg::STEP_DOWN;
                    end else begin
                        cmd.start = far_ccw[lrsr_pkg::IDX_W-1:0];
                        cmd.step  = lrsr_pkg::STEP_UP;
                    end
                end else begin
                    cmd.step = cw_eff ? lrsr_pkg::STEP_UP : lrsr_pkg::STEP_DOWN;
                end
            end
        endcase
    end

    assign push_cmd   = cmd;
    assign push_valid = (state_reg == lrsr_pkg::F_PUSH);
    assign s_ready    = (state_reg == lrsr_pkg::F_IDLE);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        n_next     = n_reg;
        level_next = level_reg;
        cw_next    = cw_reg;
        vis_next   = vis_reg;
        p_next     = p_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        pq_next    = pq_reg;
        pr_next    = pr_reg;
        unique case (state_reg)
            lrsr_pkg::F_IDLE: begin
                if (s_valid) begin
                    kind_next  = lrsr_pkg::kind_t'(s_kind);
                    n_next     = n_clamp;
                    level_next = s_level;
                    cw_next    = s_clockwise;
                    vis_next   = s_visible;
                    p_next     = ring_mod(s_position);
                    dvd_next   = R_W;
                    dvs_next   = n_clamp;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    if (lrsr_pkg::kind_t'(s_kind) == lrsr_pkg::KIND_POLYGON) begin
                        state_next = lrsr_pkg::F_DIVN;
                    end else begin
                        state_next = lrsr_pkg::F_PUSH;
                    end
                end
            end
            lrsr_pkg::F_DIVN: begin
                rem_next = rem_step;
                quo_next = quo_step;
                dvd_next = {dvd_reg[lrsr_pkg::DW-2:0], 1'b0};
                cnt_next = cnt_reg + lrsr_pkg::SC_W'(1);
                if (last_step) begin
                    pq_next    = quo_step;
                    pr_next    = rem_step;
                    state_next = lrsr_pkg::F_PUSH;
                end
            end
            lrsr_pkg::F_PUSH: begin
                if (push_ready) begin
                    state_next = lrsr_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = lrsr_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrsr_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        n_reg     <= n_next;
        level_reg <= level_next;
        cw_reg    <= cw_next;
        vis_reg   <= vis_next;
        p_reg     <= p_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        pq_reg    <= pq_next;
        pr_reg    <= pr_next;
    end

endmodule

@@ hdl/lrsr_fifo.sv @@
// Two-entry command queue between the front end and the write sequencer.
module lrsr_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  lrsr_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output lrsr_pkg::cmd_t pop_cmd
);

    lrsr_pkg::cmd_t            mem_reg [lrsr_pkg::Q_DEPTH];
    logic [lrsr_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lrsr_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lrsr_pkg::Q_AW:0]   fill_reg, fill_next;
    logic                      do_push, do_pop;

    assign push_ready = (fill_reg != (lrsr_pkg::Q_AW + 1)'(lrsr_pkg::Q_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + lrsr_pkg::Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + lrsr_pkg::Q_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (lrsr_pkg::Q_AW + 1)'(1);
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - (lrsr_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/lrsr_back.sv @@
// Write sequencer: walks one command and emits one LED write per cycle while the receiver accepts them.
module lrsr_back #(
    parameter int RING_SIZE = 60
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [lrsr_pkg::LVL_W-1:0] min_level,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  lrsr_pkg::cmd_t             pop_cmd,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lrsr_pkg::IDX_W-1:0] m_led_index,
    output logic [lrsr_pkg::LVL_W-1:0] m_led_level,
    output logic                       m_light,
    output logic                       m_last
);

    localparam logic [lrsr_pkg::DW-1:0]    R_W   = lrsr_pkg::DW'(RING_SIZE);
    localparam logic [lrsr_pkg::IDX_W-1:0] R_TOP = lrsr_pkg::IDX_W'(RING_SIZE - 1);

    logic                       busy_reg, busy_next;
    lrsr_pkg::cmd_t             cmd_reg, cmd_next;
    logic [lrsr_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [lrsr_pkg::DW-1:0]    left_reg, left_next;
    logic [lrsr_pkg::LVL_W-1:0] lvl_reg, lvl_next;
    logic [lrsr_pkg::DW-1:0]    acc_reg, acc_next;
    logic                       m_valid_reg, m_valid_next;
    logic [lrsr_pkg::IDX_W-1:0] m_index_reg, m_index_next;
    logic [lrsr_pkg::LVL_W-1:0] m_level_reg, m_level_next;
    logic                       m_light_reg, m_light_next;
    logic                       m_last_reg, m_last_next;

    logic                       emit, is_last;
    logic [lrsr_pkg::DW-1:0]    acc_sum, adv, poly_sum;
    logic                       carry;
    logic [lrsr_pkg::IDX_W-1:0] idx_adv;

    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign is_last   = (left_reg == lrsr_pkg::DW'(1));
    assign pop_ready = !busy_reg;

    // Polygon vertices: quotient plus a carry from the running remainder.
    always_comb begin
        acc_sum  = acc_reg + cmd_reg.rem;
        carry    = (acc_sum >= cmd_reg.sides);
        adv      = cmd_reg.quo + lrsr_pkg::DW'(carry);
        poly_sum = {1'b0, idx_reg} + adv;
        if (poly_sum >= R_W) begin
            poly_sum = poly_sum - R_W;
        end
    end

    always_comb begin
        unique case (cmd_reg.step)
            lrsr_pkg::STEP_UP:
                idx_adv = (idx_reg == R_TOP) ? '0 : idx_reg + lrsr_pkg::IDX_W'(1);
            lrsr_pkg::STEP_DOWN:
                idx_adv = (idx_reg == '0) ? R_TOP : idx_reg - lrsr_pkg::IDX_W'(1);
            lrsr_pkg::STEP_POLY: idx_adv = poly_sum[lrsr_pkg::IDX_W-1:0];
            default:             idx_adv = idx_reg;
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        lvl_next     = lvl_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_index_next = m_index_reg;
        m_level_next = m_level_reg;
        m_light_next = m_light_reg;
        m_last_next  = m_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next = 1'b1;
            m_index_next = idx_reg;
            m_level_next = lvl_reg;
            m_light_next = cmd_reg.light;
            m_last_next  = is_last;
            idx_next     = idx_adv;
            left_next    = left_reg - lrsr_pkg::DW'(1);
            acc_next     = carry ? (acc_sum - cmd_reg.sides) : acc_sum;
            if (cmd_reg.snake && (lvl_reg > min_level)) begin
                lvl_next = lvl_reg - lrsr_pkg::LVL_W'(1);
            end
            if (is_last) begin
                busy_next = 1'b0;
            end
        end else if (!busy_reg && pop_valid) begin
            busy_next = 1'b1;
            cmd_next  = pop_cmd;
            idx_next  = pop_cmd.start;
            left_next = pop_cmd.count;
            lvl_next  = pop_cmd.level;
            acc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        left_reg    <= left_next;
        lvl_reg     <= lvl_next;
        acc_reg     <= acc_next;
        m_index_reg <= m_index_next;
        m_level_reg <= m_level_next;
        m_light_reg <= m_light_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_led_index = m_index_reg;
    assign m_led_level = m_level_reg;
    assign m_light     = m_light_reg;
    assign m_last      = m_last_reg;

endmodule

@@ hdl/lrsr_checker.sv @@
// Port-level checker for the LED ring shape rasterizer and its bind statement.
module lrsr_checker #(
    parameter int RING_SIZE = 60
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [lrsr_pkg::KIND_W-1:0] s_kind,
    input logic [lrsr_pkg::IDX_W-1:0]  s_position,
    input logic [lrsr_pkg::EXT_W-1:0]  s_extent,
    input logic [lrsr_pkg::LVL_W-1:0]  s_level,
    input logic                        s_clockwise,
    input logic                        s_visible,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [lrsr_pkg::IDX_W-1:0]  m_led_index,
    input logic [lrsr_pkg::LVL_W-1:0]  m_led_level,
    input logic                        m_light,
    input logic                        m_last
);

    // A write always addresses an LED on the ring.
    a_index_on_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_led_index < lrsr_pkg::IDX_W'(RING_SIZE - 1))
                 || (m_led_index == lrsr_pkg::IDX_W'(RING_SIZE - 1)))
        else $error("LED index beyond the ring");

    // A switch-off write carries level zero.
    a_off_is_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_light) |-> (m_led_level == '0))
        else $error("switch-off write with nonzero level");

    // Reset drops any pending write.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("write pending right after reset");

    // A stalled write holds its payload.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_led_index)
            && $stable(m_led_level) && $stable(m_light) && $stable(m_last))
        else $error("stalled write changed");

    // A waiting command is held unchanged by the sender.
    a_cmd_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> s_valid && $stable(s_kind) && $stable(s_position)
            && $stable(s_extent) && $stable(s_level) && $stable(s_clockwise)
            && $stable(s_visible))
        else $error("waiting command changed");

endmodule

bind led_ring_shape_rasterizer lrsr_checker #(.RING_SIZE(RING_SIZE)) u_lrsr_checker (.*);
